/* hdl/frfcfs_pkg.sv */
// ----------------------------------------------------------------------------
// FR-FCFS scheduler package
// Widths, operation and status codes, and the structs that the queue cells
// share with the top level.
// ----------------------------------------------------------------------------
package frfcfs_pkg;

  localparam int NUM_BANKS   = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int ROW_BITS    = 16;
  localparam int TAG_BITS    = 8;
  localparam int BANK_W      = 4;
  localparam int OP_W        = 3;
  localparam int CAP_W       = 8;
  localparam int CAP_RESET   = 128;
  localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MIN_PAIR    = 2;
  localparam int CNT_W       = $clog2(MIN_PAIR + 1);

  typedef enum logic [OP_W-1:0] {
    OP_STORE    = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_NEXT     = 3'd2,
    OP_ROW_PAIR = 3'd3,
    OP_TWO_REQ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic                occupied;
    logic                write_en;
    logic                remove_go;
  } cell_ctl_t;

  typedef struct packed {
    logic                hit_found;
    logic [TAG_BITS-1:0] hit_tag;
    logic [CNT_W-1:0]    row_cnt;
    logic                rm_found;
  } chain_t;

endpackage

/* hdl/frfcfs_if.sv */
// ----------------------------------------------------------------------------
// FR-FCFS scheduler channels
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------
interface frfcfs_req_if;
  logic                                valid;
  logic                                ready;
  logic [frfcfs_pkg::OP_W-1:0]         opcode;
  logic [frfcfs_pkg::BANK_W-1:0]       bank;
  logic [frfcfs_pkg::ROW_BITS-1:0]     row;
  logic [frfcfs_pkg::TAG_BITS-1:0]     request_tag;
  logic                                bank_activated;

  modport source (output valid, opcode, bank, row, request_tag, bank_activated,
                  input ready);
  modport sink (input valid, opcode, bank, row, request_tag, bank_activated,
                output ready);
endinterface

interface frfcfs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [frfcfs_pkg::TAG_BITS-1:0]     chosen_tag;
  logic                                was_row_hit;
  logic                                answer;
  logic                                has_space;

  modport source (output valid, status, chosen_tag, was_row_hit, answer, has_space,
                  input ready);
  modport sink (input valid, status, chosen_tag, was_row_hit, answer, has_space,
                output ready);
endinterface

interface frfcfs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [frfcfs_pkg::CAP_W-1:0]        buffer_capacity;

  modport source (output valid, buffer_capacity, input ready);
  modport sink (input valid, buffer_capacity, output ready);
endinterface

/* hdl/frfcfs_cell.sv */
// ----------------------------------------------------------------------------
// FR-FCFS queue cell
// Holds one queue slot for every bank, compares it against the request and
// passes the first-match, row-count and remove-match chain on to the next cell.
// ----------------------------------------------------------------------------
module frfcfs_cell (
  input  logic                            clk_i,
  input  logic [frfcfs_pkg::BANK_W-1:0]   bank_i,
  input  logic [frfcfs_pkg::ROW_BITS-1:0] row_i,
  input  logic [frfcfs_pkg::TAG_BITS-1:0] tag_i,
  input  frfcfs_pkg::cell_ctl_t           ctl_i,
  input  frfcfs_pkg::entry_t              next_entry_i,
  output frfcfs_pkg::entry_t              entry_o,
  input  frfcfs_pkg::chain_t              chain_i,
  output frfcfs_pkg::chain_t              chain_o
);

  frfcfs_pkg::entry_t mem_q [frfcfs_pkg::NUM_BANKS];
  logic               row_eq;
  logic               tag_eq;

  assign entry_o = mem_q[bank_i];
  assign row_eq  = ctl_i.occupied && (entry_o.row == row_i);
  assign tag_eq  = ctl_i.occupied && (entry_o.tag == tag_i);

  always_comb begin
    chain_o.hit_found = chain_i.hit_found | row_eq;
    chain_o.hit_tag   = (!chain_i.hit_found && row_eq) ? entry_o.tag : chain_i.hit_tag;
    chain_o.row_cnt   = (row_eq && (chain_i.row_cnt != frfcfs_pkg::CNT_W'(frfcfs_pkg::MIN_PAIR)))
                        ? chain_i.row_cnt + 1'b1 : chain_i.row_cnt;
    chain_o.rm_found  = chain_i.rm_found | tag_eq;
  end

  // Slots at and behind the removed request take their successor's entry.
  always_ff @(posedge clk_i) begin
    if (ctl_i.write_en) begin
      mem_q[bank_i] <= '{row: row_i, tag: tag_i};
    end else if (ctl_i.remove_go && chain_o.rm_found) begin
      mem_q[bank_i] <= next_entry_i;
    end
  end

endmodule

/* hdl/frfcfs_bank_request_scheduler.sv */
// ----------------------------------------------------------------------------
// FR-FCFS bank request scheduler
// Per-bank arrival-ordered request queues with row-hit-first selection when the bank is activated.
// ----------------------------------------------------------------------------
// Each request's result is registered in the output register when the request
// is accepted; a new request is accepted in every cycle in which
// the output register is empty or being read, so one request per cycle is
// sustained. The queues live in a chain of QUEUE_DEPTH cells, one slot of every
// bank each, and the first-match search runs along that chain within the cycle.
// The capacity register is written through its own channel, always ready.
module frfcfs_bank_request_scheduler (
  input  logic         clk_i,
  input  logic         rst_ni,
  frfcfs_req_if.sink   req_i,
  frfcfs_rsp_if.source rsp_o,
  frfcfs_cfg_if.sink   cfg_i
);

  logic [frfcfs_pkg::LEN_W-1:0] lens_q [frfcfs_pkg::NUM_BANKS];
  logic [frfcfs_pkg::CAP_W-1:0] total_q, total_d;
  logic [frfcfs_pkg::CAP_W-1:0] cap_q;

  logic                         out_valid_q;
  logic [1:0]                   status_q;
  logic [frfcfs_pkg::TAG_BITS-1:0] chosen_q;
  logic                         hit_q;
  logic                         answer_q;
  logic                         space_q;

  frfcfs_pkg::op_e              op;
  logic                         accept;
  logic                         bank_ok;
  logic [frfcfs_pkg::LEN_W-1:0] n;
  logic                         store_ok;
  logic                         remove_go;
  logic                         removed;

  frfcfs_pkg::status_e          status_d;
  logic [frfcfs_pkg::TAG_BITS-1:0] chosen_d;
  logic                         hit_d;
  logic                         answer_d;

  frfcfs_pkg::entry_t           ent   [frfcfs_pkg::QUEUE_DEPTH];
  frfcfs_pkg::chain_t           chain [frfcfs_pkg::QUEUE_DEPTH+1];
  frfcfs_pkg::cell_ctl_t        ctl   [frfcfs_pkg::QUEUE_DEPTH];

  assign op          = frfcfs_pkg::op_e'(req_i.opcode);
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign bank_ok     = ({1'b0, req_i.bank} < (frfcfs_pkg::BANK_W+1)'(frfcfs_pkg::NUM_BANKS));
  assign n           = bank_ok ? lens_q[req_i.bank] : '0;
  assign store_ok    = bank_ok && (total_q < cap_q) &&
                       (n < frfcfs_pkg::LEN_W'(frfcfs_pkg::QUEUE_DEPTH));
  assign remove_go   = accept && (op == frfcfs_pkg::OP_REMOVE);
  assign removed     = chain[frfcfs_pkg::QUEUE_DEPTH].rm_found;
  assign chain[0]    = '0;

  for (genvar k = 0; k < frfcfs_pkg::QUEUE_DEPTH; k++) begin : g_cell
    frfcfs_pkg::entry_t next_entry;

    assign ctl[k].occupied  = (frfcfs_pkg::LEN_W'(k) < n);
    assign ctl[k].write_en  = accept && (op == frfcfs_pkg::OP_STORE) && store_ok &&
                              (n == frfcfs_pkg::LEN_W'(k));
    assign ctl[k].remove_go = remove_go;

    if (k + 1 < frfcfs_pkg::QUEUE_DEPTH) begin : g_mid
      assign next_entry = ent[k+1];
    end else begin : g_last
      assign next_entry = '0;
    end

    frfcfs_cell u_cell (
      .clk_i        (clk_i),
      .bank_i       (req_i.bank),
      .row_i        (req_i.row),
      .tag_i        (req_i.request_tag),
      .ctl_i        (ctl[k]),
      .next_entry_i (next_entry),
      .entry_o      (ent[k]),
      .chain_i      (chain[k]),
      .chain_o      (chain[k+1])
    );
  end

  always_comb begin
    status_d = frfcfs_pkg::ST_OK;
    chosen_d = '0;
    hit_d    = 1'b0;
    answer_d = 1'b0;
    total_d  = total_q;
    unique case (op)
      frfcfs_pkg::OP_STORE: begin
        if (store_ok) begin
          total_d = total_q + 1'b1;
        end else begin
          status_d = frfcfs_pkg::ST_FULL;
        end
      end
      frfcfs_pkg::OP_REMOVE: begin
        if (removed) begin
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
        end else begin
          status_d = frfcfs_pkg::ST_EMPTY;
        end
      end
      frfcfs_pkg::OP_NEXT: begin
        if (n == '0) begin
          status_d = frfcfs_pkg::ST_EMPTY;
        end else if (req_i.bank_activated && chain[frfcfs_pkg::QUEUE_DEPTH].hit_found) begin
          chosen_d = chain[frfcfs_pkg::QUEUE_DEPTH].hit_tag;
          hit_d    = 1'b1;
        end else begin
          chosen_d = ent[0].tag;
        end
      end
      frfcfs_pkg::OP_ROW_PAIR: begin
        answer_d = (chain[frfcfs_pkg::QUEUE_DEPTH].row_cnt ==
                    frfcfs_pkg::CNT_W'(frfcfs_pkg::MIN_PAIR));
      end
      frfcfs_pkg::OP_TWO_REQ: begin
        answer_d = (n >= frfcfs_pkg::LEN_W'(frfcfs_pkg::MIN_PAIR));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < frfcfs_pkg::NUM_BANKS; b++) begin
        lens_q[b] <= '0;
      end
      total_q     <= '0;
      cap_q       <= frfcfs_pkg::CAP_W'(frfcfs_pkg::CAP_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.buffer_capacity;
      end
      if (accept) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
        if (op == frfcfs_pkg::OP_STORE && store_ok) begin
          lens_q[req_i.bank] <= n + 1'b1;
        end else if (op == frfcfs_pkg::OP_REMOVE && removed) begin
          lens_q[req_i.bank] <= n - 1'b1;
        end
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      chosen_q <= chosen_d;
      hit_q    <= hit_d;
      answer_q <= answer_d;
      space_q  <= (total_d < cap_q);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.chosen_tag  = chosen_q;
  assign rsp_o.was_row_hit = hit_q;
  assign rsp_o.answer      = answer_q;
  assign rsp_o.has_space   = space_q;

`ifndef SYNTHESIS
  a_store_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == frfcfs_pkg::OP_STORE && store_ok |=> total_q == $past(total_q) + 1'b1)
    else $error("stored total did not grow on an accepted store");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> n <= frfcfs_pkg::LEN_W'(frfcfs_pkg::QUEUE_DEPTH))
    else $error("bank queue length exceeds the queue depth");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hit_q |-> status_q == frfcfs_pkg::ST_OK)
    else $error("row hit reported with a failing status");

  a_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remove_go && n == '0 |-> !removed)
    else $error("remove matched in an empty queue");
`endif

endmodule
